/* rtl/mhpq_pkg.sv */
// Shared types, codes and sizes of the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int FIELD_W      = 16;
   localparam int ENTRY_W      = 3 * FIELD_W;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 7;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] prio;
      logic [FIELD_W-1:0] pages;
      logic [FIELD_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic start;
      logic rd_last;
      logic rd_parent;
      logic rd_left;
      logic rd_right;
      logic take_last;
      logic place;
      logic ins_step;
      logic dn_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic op_extract;
      logic full;
      logic empty;
      logic one;
      logic at_zero;
      logic up;
      logic has_left;
      logic sink_stop;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/mhpq_if.sv */
// Request and response channel interfaces of the max-heap priority queue.
`default_nettype none

interface mhpq_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [mhpq_pkg::FIELD_W-1:0]     in_priority;
   logic [mhpq_pkg::FIELD_W-1:0]     in_pages;
   logic [mhpq_pkg::FIELD_W-1:0]     in_tag;

   modport source (output valid, req_type, in_priority, in_pages, in_tag, input ready);
   modport sink   (input valid, req_type, in_priority, in_pages, in_tag, output ready);
endinterface

interface mhpq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mhpq_pkg::STATUS_W-1:0]    status;
   logic [mhpq_pkg::FIELD_W-1:0]     out_priority;
   logic [mhpq_pkg::FIELD_W-1:0]     out_pages;
   logic [mhpq_pkg::FIELD_W-1:0]     out_tag;
   logic [mhpq_pkg::COUNT_OUT_W-1:0] out_count;
   logic                             top_valid;
   logic [mhpq_pkg::FIELD_W-1:0]     top_priority;

   modport source (output valid, status, out_priority, out_pages, out_tag, out_count,
                   top_valid, top_priority, input ready);
   modport sink   (input valid, status, out_priority, out_pages, out_tag, out_count,
                   top_valid, top_priority, output ready);
endinterface

`default_nettype wire

/* rtl/max_heap_priority_queue_core.sv */
// Top level of the binary max-heap priority queue core.
//
//   Channel  Direction  Word
//   req_ch   in         req_type, in_priority, in_pages, in_tag
//   rsp_ch   out        status, out_priority, out_pages, out_tag, out_count,
//                       top_valid, top_priority
//
// One word at a time: insert and extract each move through the heap level by level, since the
// single store read port needs a parent read per level up and two child reads per level down.
// Refused words and an extract of the last entry go from the check straight to the response.
// Reset clears the count and control; the store needs no clearing.
// A stalled response holds in its output register while the next word runs.
`default_nettype none

module max_heap_priority_queue_core #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_ch,
   mhpq_rsp_if.source  rsp_ch
);

   mhpq_pkg::cmd_type  cmd;
   mhpq_pkg::stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_ch.req_type),
      .in_priority  (req_ch.in_priority),
      .in_pages     (req_ch.in_pages),
      .in_tag       (req_ch.in_tag),
      .status       (rsp_ch.status),
      .out_priority (rsp_ch.out_priority),
      .out_pages    (rsp_ch.out_pages),
      .out_tag      (rsp_ch.out_tag),
      .out_count    (rsp_ch.out_count),
      .top_valid    (rsp_ch.top_valid),
      .top_priority (rsp_ch.top_priority)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while a word is in flight");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status != mhpq_pkg::STATUS_OK) |->
      (rsp_ch.out_priority == '0) && (rsp_ch.out_pages == '0) && (rsp_ch.out_tag == '0))
      else $error("refused word carries a nonzero entry");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.top_valid |-> (rsp_ch.top_priority == '0))
      else $error("empty heap reports a top priority");

   a_empty_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == mhpq_pkg::STATUS_EMPTY) |-> !rsp_ch.top_valid)
      else $error("empty refusal with a valid top");

endmodule

`default_nettype wire

/* rtl/mhpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = mhpq_pkg::ENTRY_W,
   parameter int DEPTH = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mhpq_ctrl.sv */
// Controller state machine: sequences insert sift-up and extract sift-down.
`default_nettype none

module mhpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mhpq_pkg::stat_type stat,
   output mhpq_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_UP,
      ST_INS_CMP,
      ST_EXT_LAST,
      ST_DN_L,
      ST_DN_R,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.start = 1'b1;
            if (stat.op_extract) begin
               if (stat.empty || stat.one) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.rd_last = 1'b1;
                  state_in    = ST_EXT_LAST;
               end
            end else if (stat.full) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_INS_UP;
            end
         end
         ST_INS_UP: begin
            if (stat.at_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            cmd.ins_step = 1'b1;
            state_in     = stat.up ? ST_INS_UP : ST_DONE;
         end
         ST_EXT_LAST: begin
            cmd.take_last = 1'b1;
            state_in      = ST_DN_L;
         end
         ST_DN_L: begin
            if (stat.has_left) begin
               cmd.rd_left = 1'b1;
               state_in    = ST_DN_R;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DN_R: begin
            cmd.rd_right = 1'b1;
            state_in     = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            cmd.dn_step = 1'b1;
            state_in    = stat.sink_stop ? ST_DONE : ST_DN_L;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/mhpq_dp.sv */
// Datapath: heap store, entry count, hole index, compares and response word.
`default_nettype none

module mhpq_dp #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mhpq_pkg::cmd_type                cmd,
   output mhpq_pkg::stat_type               stat,
   input  logic                             req_type,
   input  logic [mhpq_pkg::FIELD_W-1:0]     in_priority,
   input  logic [mhpq_pkg::FIELD_W-1:0]     in_pages,
   input  logic [mhpq_pkg::FIELD_W-1:0]     in_tag,
   output logic [mhpq_pkg::STATUS_W-1:0]    status,
   output logic [mhpq_pkg::FIELD_W-1:0]     out_priority,
   output logic [mhpq_pkg::FIELD_W-1:0]     out_pages,
   output logic [mhpq_pkg::FIELD_W-1:0]     out_tag,
   output logic [mhpq_pkg::COUNT_OUT_W-1:0] out_count,
   output logic                             top_valid,
   output logic [mhpq_pkg::FIELD_W-1:0]     top_priority
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IW  = AW + 2;
   localparam int OCW = mhpq_pkg::COUNT_OUT_W;

   logic [CW-1:0]                    count_ff, count_in;
   logic [AW-1:0]                    at_ff, at_in;
   logic                             op_ff, op_in;
   mhpq_pkg::entry_type              item_ff, item_in;
   mhpq_pkg::entry_type              left_ff, left_in;
   mhpq_pkg::entry_type              root_ff, root_in;
   logic [mhpq_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   mhpq_pkg::entry_type              res_entry_ff, res_entry_in;
   logic [mhpq_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   mhpq_pkg::entry_type              rsp_entry_ff, rsp_entry_in;
   logic [OCW-1:0]                   rsp_count_ff, rsp_count_in;
   logic                             rsp_top_valid_ff, rsp_top_valid_in;
   logic [mhpq_pkg::FIELD_W-1:0]     rsp_top_prio_ff, rsp_top_prio_in;

   logic                             wr_en, rd_en;
   logic [AW-1:0]                    wr_addr, rd_addr;
   mhpq_pkg::entry_type              wr_data, rd_entry;
   logic [mhpq_pkg::ENTRY_W-1:0]     rd_data;

   logic [AW-1:0]                    at_m1, parent_idx, last_idx, child_idx;
   logic [CW-1:0]                    count_m1;
   logic [IW-1:0]                    l_idx, r_idx, count_ext;
   logic                             is_extract, full, empty, has_left, has_right;
   logic                             up, left_gt, right_take, sink_stop;
   mhpq_pkg::entry_type              best, child_entry;

   mhpq_ram #(
      .WIDTH (mhpq_pkg::ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_entry    = rd_data;
      is_extract  = (op_ff == mhpq_pkg::OP_EXTRACT);
      full        = (count_ff == CW'(CAPACITY));
      empty       = (count_ff == '0);
      at_m1       = at_ff - AW'(1);
      parent_idx  = AW'(at_m1 >> 1);
      count_m1    = count_ff - CW'(1);
      last_idx    = count_m1[AW-1:0];
      l_idx       = {1'b0, at_ff, 1'b1};
      r_idx       = l_idx + IW'(1);
      count_ext   = IW'(count_ff);
      has_left    = (l_idx < count_ext);
      has_right   = (r_idx < count_ext);
      up          = (item_ff.prio > rd_entry.prio);
      left_gt     = (left_ff.prio > item_ff.prio);
      best        = left_gt ? left_ff : item_ff;
      right_take  = has_right && (rd_entry.prio > best.prio);
      sink_stop   = !left_gt && !right_take;
      child_entry = right_take ? rd_entry : left_ff;
      child_idx   = right_take ? r_idx[AW-1:0] : l_idx[AW-1:0];

      stat.op_extract = is_extract;
      stat.full       = full;
      stat.empty      = empty;
      stat.one        = (count_ff == CW'(1));
      stat.at_zero    = (at_ff == '0);
      stat.up         = up;
      stat.has_left   = has_left;
      stat.sink_stop  = sink_stop;
   end

   always_comb begin
      rd_en   = cmd.rd_last | cmd.rd_parent | cmd.rd_left | cmd.rd_right;
      rd_addr = at_ff;
      if (cmd.rd_last) begin
         rd_addr = last_idx;
      end else if (cmd.rd_parent) begin
         rd_addr = parent_idx;
      end else if (cmd.rd_left) begin
         rd_addr = l_idx[AW-1:0];
      end else if (cmd.rd_right) begin
         rd_addr = r_idx[AW-1:0];
      end
      if (cmd.rd_right && !has_right) begin
         rd_en = 1'b0;
      end

      wr_en   = cmd.place | cmd.ins_step | cmd.dn_step;
      wr_addr = at_ff;
      wr_data = item_ff;
      if (cmd.ins_step && up) begin
         wr_data = rd_entry;
      end else if (cmd.dn_step && !sink_stop) begin
         wr_data = child_entry;
      end
   end

   always_comb begin
      count_in         = count_ff;
      at_in            = at_ff;
      op_in            = op_ff;
      item_in          = item_ff;
      left_in          = left_ff;
      root_in          = root_ff;
      res_status_in    = res_status_ff;
      res_entry_in     = res_entry_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_entry_in     = rsp_entry_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_top_prio_in  = rsp_top_prio_ff;

      if (cmd.load_req) begin
         op_in   = req_type;
         item_in = '{prio: in_priority, pages: in_pages, tag: in_tag};
      end
      if (cmd.start) begin
         res_status_in = mhpq_pkg::STATUS_OK;
         res_entry_in  = '0;
         if (is_extract) begin
            at_in = '0;
            if (empty) begin
               res_status_in = mhpq_pkg::STATUS_EMPTY;
            end else begin
               res_entry_in = root_ff;
               count_in     = count_m1;
            end
         end else begin
            at_in = count_ff[AW-1:0];
            if (full) begin
               res_status_in = mhpq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
      end
      if (cmd.take_last) begin
         item_in = rd_entry;
      end
      if (cmd.rd_right) begin
         left_in = rd_entry;
      end
      if (cmd.ins_step && up) begin
         at_in = parent_idx;
      end
      if (cmd.dn_step && !sink_stop) begin
         at_in = child_idx;
      end
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
      if (cmd.rsp_load) begin
         rsp_status_in    = res_status_ff;
         rsp_entry_in     = res_entry_ff;
         rsp_count_in     = OCW'(count_ff);
         rsp_top_valid_in = !empty;
         rsp_top_prio_in  = empty ? '0 : root_ff.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      at_ff            <= at_in;
      op_ff            <= op_in;
      item_ff          <= item_in;
      left_ff          <= left_in;
      root_ff          <= root_in;
      res_status_ff    <= res_status_in;
      res_entry_ff     <= res_entry_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_entry_ff     <= rsp_entry_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_top_prio_ff  <= rsp_top_prio_in;
   end

   assign status       = rsp_status_ff;
   assign out_priority = rsp_entry_ff.prio;
   assign out_pages    = rsp_entry_ff.pages;
   assign out_tag      = rsp_entry_ff.tag;
   assign out_count    = rsp_count_ff;
   assign top_valid    = rsp_top_valid_ff;
   assign top_priority = rsp_top_prio_ff;

endmodule

`default_nettype wire
